// ===== hw/rtl/afsrl_pkg.sv =====
package afsrl_pkg;

    localparam int NUM_CHANNELS_DEF = 8;
    localparam int RING_DEPTH_DEF   = 64;

    localparam int CH_W      = 3;
    localparam int BYTE_W    = 8;
    localparam int SAMPLE_W  = 12;
    localparam int SLOT_W    = 6;
    localparam int CMD_W     = 24;
    localparam int MASK_W    = 8;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_LIMIT   = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_ENABLE = 1'b1;

    localparam logic [SAMPLE_W-1:0] SAMPLE_LIMIT_RST = 12'hFFF;
    localparam logic [MASK_W-1:0]   CHANNEL_MASK_RST = 8'hFF;

    // single-ended start command: start bit, SGL/DIFF, D2..D0
    localparam logic [4:0] CMD_START_SGL = 5'h18;
    localparam int         CMD_SHIFT     = 14;
    localparam logic [3:0] NIBBLE_MASK   = 4'hF;

    typedef enum logic [1:0] {
        STATUS_STORED     = 2'd0,
        STATUS_OVER_LIMIT = 2'd1,
        STATUS_SHORT      = 2'd2,
        STATUS_DISABLED   = 2'd3
    } status_t;

    function automatic logic [CMD_W-1:0] start_command(input logic [CH_W-1:0] ch);
        logic [4:0] code;
        code = CMD_START_SGL ^ {2'b00, ch};
        return {{(CMD_W - 5 - CMD_SHIFT){1'b0}}, code, {CMD_SHIFT{1'b0}}};
    endfunction

    function automatic logic [SAMPLE_W-1:0] reply_sample(input logic [BYTE_W-1:0] mid,
                                                         input logic [BYTE_W-1:0] low);
        return {mid[3:0] & NIBBLE_MASK, low};
    endfunction

endpackage

// ===== hw/rtl/afsrl_frame_if.sv =====
interface afsrl_frame_if;
    logic                            valid;
    logic                            ready;
    logic [afsrl_pkg::CH_W-1:0]      adc_channel;
    logic [afsrl_pkg::BYTE_W-1:0]    reply_mid_byte;
    logic [afsrl_pkg::BYTE_W-1:0]    reply_low_byte;
    logic                            reply_complete;

    modport source (output valid, adc_channel, reply_mid_byte, reply_low_byte,
                    reply_complete, input ready);
    modport sink   (input valid, adc_channel, reply_mid_byte, reply_low_byte,
                    reply_complete, output ready);
endinterface

// ===== hw/rtl/afsrl_result_if.sv =====
interface afsrl_result_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [afsrl_pkg::SAMPLE_W-1:0]   sample_value;
    logic [afsrl_pkg::SLOT_W-1:0]     write_slot;
    logic                             ring_full;
    logic                             dropped_oldest;
    logic [afsrl_pkg::CMD_W-1:0]      command_word;

    modport source (output valid, status, sample_value, write_slot, ring_full,
                    dropped_oldest, command_word, input ready);
    modport sink   (input valid, status, sample_value, write_slot, ring_full,
                    dropped_oldest, command_word, output ready);
endinterface

// ===== hw/rtl/afsrl_ram.sv =====
module afsrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read during write to the same address returns the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hw/rtl/adc_frame_sample_ring_logger.sv =====
// Logs 12-bit converter samples into one ring per channel and returns, for
// every frame beat, one result beat with the status, the sample, the ring slot
// written and the channel's start command. One frame is taken every cycle
// while the output is not stalled; a frame is held in stage 1 and its result
// then waits in an output register, so a new frame can enter stage 1 while
// one result is pending. Ring pointers live in a NUM_CHANNELS-entry RAM that
// is read when a frame is accepted and written back when its sample is stored;
// a forwarding register covers two back-to-back frames of the same channel.
// Per-channel valid bits make the pointers read as zero after reset, so there
// is no clearing pass. Samples go to a NUM_CHANNELS*RING_DEPTH write-only RAM.
module adc_frame_sample_ring_logger #(
    parameter int NUM_CHANNELS = afsrl_pkg::NUM_CHANNELS_DEF,
    parameter int RING_DEPTH   = afsrl_pkg::RING_DEPTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [afsrl_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [afsrl_pkg::CFG_DATA_W-1:0]    cfg_data,
    afsrl_frame_if.sink                         frame_in,
    afsrl_result_if.source                      result_out
);

    localparam int AW     = $clog2(RING_DEPTH);
    localparam int CH_AW  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int RS_W   = 2 * AW + 1;
    localparam int SDEPTH = NUM_CHANNELS * RING_DEPTH;
    localparam int SA_W   = $clog2(SDEPTH);
    localparam logic [AW-1:0] HEAD_LAST = AW'(RING_DEPTH - 1);

    // configuration
    logic [afsrl_pkg::SAMPLE_W-1:0] sample_limit_reg;
    logic [afsrl_pkg::MASK_W-1:0]   channel_mask_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_limit_reg <= afsrl_pkg::SAMPLE_LIMIT_RST;
            channel_mask_reg <= afsrl_pkg::CHANNEL_MASK_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                afsrl_pkg::REG_SAMPLE_LIMIT:
                    sample_limit_reg <= cfg_data[afsrl_pkg::SAMPLE_W-1:0];
                afsrl_pkg::REG_CHANNEL_ENABLE:
                    channel_mask_reg <= cfg_data[afsrl_pkg::MASK_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // handshake
    logic s1_valid_reg;
    logic out_valid_reg;
    logic s1_adv;
    logic in_accept;

    assign s1_adv         = s1_valid_reg && (!out_valid_reg || result_out.ready);
    assign frame_in.ready = !s1_valid_reg || s1_adv;
    assign in_accept      = frame_in.valid && frame_in.ready;

    // stage 1 payload
    logic [afsrl_pkg::CH_W-1:0]   s1_ch_reg;
    logic [afsrl_pkg::BYTE_W-1:0] s1_mid_reg;
    logic [afsrl_pkg::BYTE_W-1:0] s1_low_reg;
    logic                         s1_complete_reg;

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_ch_reg       <= frame_in.adc_channel;
            s1_mid_reg      <= frame_in.reply_mid_byte;
            s1_low_reg      <= frame_in.reply_low_byte;
            s1_complete_reg <= frame_in.reply_complete;
        end
    end

    // ring state RAM: {full, tail, head}
    logic              ring_we;
    logic [CH_AW-1:0]  s1_idx;
    logic [RS_W-1:0]   ring_wdata;
    logic [RS_W-1:0]   ring_rdata;

    assign s1_idx = CH_AW'(s1_ch_reg);

    afsrl_ram #(
        .WIDTH (RS_W),
        .DEPTH (NUM_CHANNELS)
    ) u_ring_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (s1_idx),
        .wdata (ring_wdata),
        .re    (in_accept),
        .raddr (CH_AW'(frame_in.adc_channel)),
        .rdata (ring_rdata)
    );

    // forwarding of the last write-back, plus per-channel written marks
    logic              fwd_valid_reg;
    logic [CH_AW-1:0]  fwd_idx_reg;
    logic [RS_W-1:0]   fwd_data_reg;
    logic [NUM_CHANNELS-1:0] chan_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg  <= 1'b0;
            chan_valid_reg <= '0;
        end
        else if (ring_we)
        begin
            fwd_valid_reg          <= 1'b1;
            chan_valid_reg[s1_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            fwd_idx_reg  <= s1_idx;
            fwd_data_reg <= ring_wdata;
        end
    end

    // stage 1 evaluation
    logic                            ch_in_range;
    logic                            ch_enabled;
    logic [afsrl_pkg::SAMPLE_W-1:0]  raw_sample;
    logic [RS_W-1:0]                 cur_state;
    logic [AW-1:0]                   cur_head;
    logic [AW-1:0]                   cur_tail;
    logic                            cur_full;
    logic [AW-1:0]                   new_head;
    logic [AW-1:0]                   new_tail;
    logic                            new_full;
    logic                            stored;
    afsrl_pkg::status_t              status_c;
    logic [afsrl_pkg::SAMPLE_W-1:0]  sample_c;

    always_comb
    begin
        ch_in_range = ({1'b0, s1_ch_reg} < (afsrl_pkg::CH_W + 1)'(NUM_CHANNELS));
        ch_enabled  = ch_in_range && channel_mask_reg[s1_ch_reg];
        raw_sample  = afsrl_pkg::reply_sample(s1_mid_reg, s1_low_reg);

        if (fwd_valid_reg && (fwd_idx_reg == s1_idx))
            cur_state = fwd_data_reg;
        else if (ch_in_range && chan_valid_reg[s1_idx])
            cur_state = ring_rdata;
        else
            cur_state = '0;
        cur_head = cur_state[AW-1:0];
        cur_tail = cur_state[2*AW-1:AW];
        cur_full = cur_state[RS_W-1];

        if (!ch_enabled)
        begin
            status_c = afsrl_pkg::STATUS_DISABLED;
            sample_c = '0;
        end
        else if (!s1_complete_reg)
        begin
            status_c = afsrl_pkg::STATUS_SHORT;
            sample_c = '0;
        end
        else if (raw_sample > sample_limit_reg)
        begin
            status_c = afsrl_pkg::STATUS_OVER_LIMIT;
            sample_c = raw_sample;
        end
        else
        begin
            status_c = afsrl_pkg::STATUS_STORED;
            sample_c = raw_sample;
        end
        stored = (status_c == afsrl_pkg::STATUS_STORED);

        new_head = (cur_head == HEAD_LAST) ? '0 : cur_head + 1'b1;
        if (cur_full)
            new_tail = (cur_tail == HEAD_LAST) ? '0 : cur_tail + 1'b1;
        else
            new_tail = cur_tail;
        new_full = (new_head == new_tail);

        ring_wdata = {new_full, new_tail, new_head};
    end

    assign ring_we = s1_adv && stored;

    // sample store
    logic [SA_W-1:0] store_addr;

    assign store_addr = SA_W'(s1_idx) * SA_W'(RING_DEPTH) + SA_W'(cur_head);

    afsrl_ram #(
        .WIDTH (afsrl_pkg::SAMPLE_W),
        .DEPTH (SDEPTH)
    ) u_sample_ram (
        .clk   (clk),
        .we    (ring_we),
        .waddr (store_addr),
        .wdata (sample_c),
        .re    (1'b0),
        .raddr ('0),
        .rdata ()
    );

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (frame_in.ready)
                s1_valid_reg <= frame_in.valid;
            if (s1_adv)
                out_valid_reg <= 1'b1;
            else if (result_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    logic [1:0]                      status_reg;
    logic [afsrl_pkg::SAMPLE_W-1:0]  sample_reg;
    logic [afsrl_pkg::SLOT_W-1:0]    slot_reg;
    logic                            full_reg;
    logic                            dropped_reg;
    logic [afsrl_pkg::CMD_W-1:0]     cmd_reg;

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            status_reg  <= status_c;
            sample_reg  <= sample_c;
            slot_reg    <= stored ? afsrl_pkg::SLOT_W'(cur_head) : '0;
            full_reg    <= ch_in_range && (stored ? new_full : cur_full);
            dropped_reg <= stored && cur_full;
            cmd_reg     <= afsrl_pkg::start_command(s1_ch_reg);
        end
    end

    assign result_out.valid          = out_valid_reg;
    assign result_out.status         = status_reg;
    assign result_out.sample_value   = sample_reg;
    assign result_out.write_slot     = slot_reg;
    assign result_out.ring_full      = full_reg;
    assign result_out.dropped_oldest = dropped_reg;
    assign result_out.command_word   = cmd_reg;

    // checks
    a_drop_keeps_full: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.dropped_oldest) |->
            (result_out.ring_full && result_out.status == afsrl_pkg::STATUS_STORED))
        else $error("overwrite reported without a full ring");

    a_reject_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && result_out.status != afsrl_pkg::STATUS_STORED) |->
            (result_out.write_slot == '0 && !result_out.dropped_oldest))
        else $error("rejected beat carries ring write info");

    a_reject_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        (result_out.valid && (result_out.status == afsrl_pkg::STATUS_DISABLED ||
                              result_out.status == afsrl_pkg::STATUS_SHORT)) |->
            (result_out.sample_value == '0))
        else $error("sample shown for disabled channel or short frame");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !result_out.ready) |-> !frame_in.ready)
        else $error("frame accepted while both stages are blocked");

endmodule
